// ----- hdl/nsr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared widths, register indexes, reset values and first-guess coefficients
// for the Newton square root block.
// ----------------------------------------------------------------------------
package nsr_pkg;

  // Default fixed-point format of the radicand and root
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 1'd1;

  // Register widths and reset values
  localparam int TOL_W  = 32;
  localparam int ITER_W = 8;

  localparam logic [TOL_W-1:0]  TOL_RESET  = 32'd1;
  localparam logic [ITER_W-1:0] ITER_RESET = 8'd100;

  // Result width and saturation value
  localparam int ROOT_W = 24;
  localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

  // First guess: (A + B*m) with m a Q0.16 mantissa in [0.5,1)
  localparam int MANT_W   = 16;
  localparam int APPROX_W = 17;
  localparam logic [MANT_W-1:0] COEF_A = 16'd27349;  // 0.41731
  localparam logic [MANT_W-1:0] COEF_B = 16'd38677;  // 0.59016

endpackage
`default_nettype wire

// ----- hdl/nsr_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_div
// Restoring divider, one quotient bit per cycle. Only the low XW quotient
// bits are kept.
// ----------------------------------------------------------------------------
module nsr_div #(
  parameter int DDW = 48,
  parameter int XW  = 26
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DDW-1:0] dividend,
  input  wire logic [XW-1:0]  divisor,
  output logic                done,
  output logic [XW-1:0]       quotient
);

  localparam int CNT_W = $clog2(DDW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DDW-1:0]   dvd_r;
  logic [XW-1:0]    dvs_r;
  logic [XW-1:0]    rem_r;
  logic [XW-1:0]    quo_r;

  logic [XW:0]      trial;
  logic [XW:0]      trial_sub;
  logic             fits;
  logic [XW-1:0]    rem_nxt;
  logic [XW-1:0]    quo_nxt;

  always_comb begin
    trial     = {rem_r, dvd_r[DDW-1]};
    trial_sub = trial - {1'b0, dvs_r};
    fits      = (trial >= {1'b0, dvs_r});
    rem_nxt   = fits ? trial_sub[XW-1:0] : trial[XW-1:0];
    quo_nxt   = {quo_r[XW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DDW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DDW-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ----- hdl/nsr_guess.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_guess
// First estimate of the root: leading-one search one bit per cycle, then
// mantissa, linear fit and exponent shift.
// ----------------------------------------------------------------------------
module nsr_guess #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int XW         = 26
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] raw,
  output logic                       done,
  output logic [XW-1:0]              guess
);

  localparam int PW  = $clog2(DATA_WIDTH);
  localparam int SHW = DATA_WIDTH + nsr_pkg::MANT_W - 1;

  typedef enum logic [4:0] {
    G_IDLE  = 5'b00001,
    G_NORM  = 5'b00010,
    G_MANT  = 5'b00100,
    G_MUL   = 5'b01000,
    G_SHIFT = 5'b10000
  } gstate_t;

  gstate_t                           state_r;
  logic                              done_r;
  logic [PW-1:0]                     p_r;
  logic [nsr_pkg::MANT_W-1:0]        m_r;
  logic [nsr_pkg::APPROX_W-1:0]      approx_r;
  logic [XW-1:0]                     guess_r;

  logic [SHW-1:0]                    mant_sh;
  logic [2*nsr_pkg::MANT_W-1:0]      prod;
  logic [nsr_pkg::APPROX_W-1:0]      approx_nxt;
  logic signed [7:0]                 e_s;
  logic signed [7:0]                 h_s;
  logic [7:0]                        h_mag;
  logic [XW-1:0]                     shifted;
  logic [XW-1:0]                     guess_nxt;

  always_comb begin
    // Leading one moved to bit MANT_W-1; bits falling off the bottom are dropped
    mant_sh    = {raw, {(nsr_pkg::MANT_W-1){1'b0}}} >> p_r;
    prod       = {{nsr_pkg::MANT_W{1'b0}}, nsr_pkg::COEF_B} *
                 {{nsr_pkg::MANT_W{1'b0}}, m_r};
    approx_nxt = nsr_pkg::APPROX_W'(nsr_pkg::COEF_A) +
                 nsr_pkg::APPROX_W'(prod[2*nsr_pkg::MANT_W-1:nsr_pkg::MANT_W]);
    // Exponent and its half, rounded toward zero
    e_s        = $signed(8'(p_r)) + 8'sd1 - $signed(8'(FRAC_BITS));
    h_s        = (e_s + $signed({7'b0, e_s[7]})) >>> 1;
    h_mag      = h_s[7] ? 8'(-h_s) : 8'(h_s);
    shifted    = h_s[7] ? (XW'(approx_r) >> h_mag) : (XW'(approx_r) << h_mag);
    guess_nxt  = (shifted == '0) ? ({{(XW-1){1'b0}}, 1'b1} << FRAC_BITS) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        G_IDLE: begin
          if (start) state_r <= G_NORM;
        end
        G_NORM: begin
          if (p_r == '0 || raw[p_r]) state_r <= G_MANT;
        end
        G_MANT: begin
          state_r <= G_MUL;
        end
        G_MUL: begin
          state_r <= G_SHIFT;
        end
        G_SHIFT: begin
          state_r <= G_IDLE;
          done_r  <= 1'b1;
        end
        default: begin
          state_r <= G_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == G_IDLE && start) begin
      p_r <= PW'(DATA_WIDTH - 1);
    end else if (state_r == G_NORM && p_r != '0 && !raw[p_r]) begin
      p_r <= p_r - PW'(1);
    end
    if (state_r == G_MANT) m_r <= mant_sh[nsr_pkg::MANT_W-1:0];
    if (state_r == G_MUL) approx_r <= approx_nxt;
    if (state_r == G_SHIFT) guess_r <= guess_nxt;
  end

  assign done  = done_r;
  assign guess = guess_r;

endmodule
`default_nettype wire

// ----- hdl/newton_square_root.sv -----
// Flow: a negative or zero radicand goes straight to the result register.
//   Otherwise the first guess is formed from a leading-one search on the
//   radicand, then the Newton steps run, each through the bit-serial divider,
//   and the last iterate is loaded into the output register.
// Throughput: one request at a time; the shared bit-serial divider sets the pace.
// Reset (rst_n low, synchronous) returns to idle and restores the registers.
`default_nettype none
// ----------------------------------------------------------------------------
// newton_square_root
// Square root of a signed fixed-point radicand by Newton-Heron iteration
// x <- (x + a/x)/2, from a linear first guess on the normalised mantissa.
// ----------------------------------------------------------------------------
module newton_square_root #(
  parameter int DATA_WIDTH = nsr_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = nsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [DATA_WIDTH-1:0]        in_value,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [nsr_pkg::ROOT_W-1:0]               out_root,
  output logic                                     out_invalid,
  // register writes
  input  wire logic                                cfg_write_en,
  input  wire logic [nsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [nsr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Iterate width: the root needs about (DATA_WIDTH+FRAC_BITS)/2 bits; a
  // little headroom covers the first guess landing above the root.
  localparam int XW_A  = (DATA_WIDTH + FRAC_BITS) / 2 + 2;
  localparam int XW_B  = nsr_pkg::APPROX_W + 1 + (DATA_WIDTH - FRAC_BITS) / 2;
  localparam int XW_C  = FRAC_BITS + 2;
  localparam int XW_AB = (XW_A > XW_B) ? XW_A : XW_B;
  localparam int XW    = (XW_AB > XW_C) ? XW_AB : XW_C;
  localparam int DDW   = DATA_WIDTH + FRAC_BITS;
  localparam int PRODW = nsr_pkg::TOL_W + XW;
  localparam int CMPW  = (XW > nsr_pkg::ROOT_W) ? XW : nsr_pkg::ROOT_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_GUESS  = 8'b0000_0010,
    S_START  = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_UPDATE = 8'b0001_0000,
    S_MULT   = 8'b0010_0000,
    S_CHECK  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t                          state_r;
  logic [nsr_pkg::TOL_W-1:0]       tol_r;
  logic [nsr_pkg::ITER_W-1:0]      iter_r;
  logic [nsr_pkg::ITER_W-1:0]      k_r;
  logic                            out_valid_r;

  logic [DATA_WIDTH-1:0]           raw_r;
  logic [XW-1:0]                   x_r;
  logic [XW-1:0]                   prev_r;
  logic [XW-1:0]                   diff_r;
  logic [PRODW-1:0]                prod_r;
  logic                            inv_r;
  logic [nsr_pkg::ROOT_W-1:0]      out_root_r;
  logic                            out_invalid_r;

  logic                            in_take;
  logic                            is_neg;
  logic                            is_zero;
  logic                            guess_start;
  logic                            guess_done;
  logic [XW-1:0]                   guess;
  logic                            div_start;
  logic                            div_done;
  logic [XW-1:0]                   quotient;
  logic [XW-1:0]                   divisor;
  logic [XW:0]                     sum;
  logic [XW-1:0]                   x_nxt;
  logic [XW-1:0]                   diff_nxt;
  logic [PRODW-1:0]                prod_nxt;
  logic                            conv;
  logic                            last_iter;
  logic                            out_free;
  logic [CMPW-1:0]                 x_ext;
  logic [nsr_pkg::ROOT_W-1:0]      root_sat;

  // --------------------------------------------------------------------------
  // Request intake: only in idle; an unread result sits in the output register
  // --------------------------------------------------------------------------
  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign is_neg   = in_value[DATA_WIDTH-1];
  assign is_zero  = (in_value == '0);

  assign guess_start = in_take && !is_neg && !is_zero;
  assign div_start   = (state_r == S_START);

  // Guard against a zero iterate before dividing
  assign divisor = (x_r == '0) ? {{(XW-1){1'b0}}, 1'b1} : x_r;

  always_comb begin
    // x_r holds the guarded divisor while the divider runs
    sum      = {1'b0, x_r} + {1'b0, quotient};
    x_nxt    = sum[XW:1];
    diff_nxt = (x_nxt >= prev_r) ? (x_nxt - prev_r) : (prev_r - x_nxt);
    prod_nxt = {{XW{1'b0}}, tol_r} * {{nsr_pkg::TOL_W{1'b0}}, x_r};
    // Relative stop: |x - xprev| * 2^32 < tolerance * x
    conv      = ({diff_r, {nsr_pkg::TOL_W{1'b0}}} < prod_r);
    last_iter = (nsr_pkg::ITER_W'(k_r + nsr_pkg::ITER_W'(1)) == iter_r);
    out_free  = !out_valid_r || !out_stall;
    // Saturate to the result field
    x_ext    = CMPW'(x_r);
    root_sat = (x_ext > CMPW'(nsr_pkg::ROOT_MAX)) ? nsr_pkg::ROOT_MAX
                                                   : x_ext[nsr_pkg::ROOT_W-1:0];
  end

  // --------------------------------------------------------------------------
  // First guess and shared divider
  // --------------------------------------------------------------------------
  nsr_guess #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .XW         (XW)
  ) u_guess (
    .clk   (clk),
    .rst_n (rst_n),
    .start (guess_start),
    .raw   (raw_r),
    .done  (guess_done),
    .guess (guess)
  );

  nsr_div #(
    .DDW (DDW),
    .XW  (XW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({raw_r, {FRAC_BITS{1'b0}}}),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // --------------------------------------------------------------------------
  // Sequencer and control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tol_r       <= nsr_pkg::TOL_RESET;
      iter_r      <= nsr_pkg::ITER_RESET;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          nsr_pkg::CFG_TOLERANCE: tol_r  <= cfg_data[nsr_pkg::TOL_W-1:0];
          nsr_pkg::CFG_MAX_ITER:  iter_r <= cfg_data[nsr_pkg::ITER_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_take) state_r <= (is_neg || is_zero) ? S_FINISH : S_GUESS;
        end
        S_GUESS: begin
          if (guess_done) begin
            k_r     <= '0;
            state_r <= (iter_r == '0) ? S_FINISH : S_START;
          end
        end
        S_START: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          state_r <= S_MULT;
        end
        S_MULT: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (conv || last_iter) begin
            state_r <= S_FINISH;
          end else begin
            k_r     <= k_r + nsr_pkg::ITER_W'(1);
            state_r <= S_START;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      raw_r <= in_value;
      inv_r <= is_neg;
      x_r   <= '0;
    end
    if (state_r == S_GUESS && guess_done) x_r <= guess;
    if (state_r == S_START) begin
      prev_r <= x_r;
      x_r    <= divisor;
    end
    if (state_r == S_UPDATE) begin
      x_r    <= x_nxt;
      diff_r <= diff_nxt;
    end
    if (state_r == S_MULT) prod_r <= prod_nxt;
    if (state_r == S_FINISH && out_free) begin
      out_root_r    <= inv_r ? '0 : root_sat;
      out_invalid_r <= inv_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_root    = out_root_r;
  assign out_invalid = out_invalid_r;

endmodule
`default_nettype wire

// ----- hdl/nsr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_checker
// Port-level checks on the Newton square root block, bound to the top level.
// ----------------------------------------------------------------------------
module nsr_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [nsr_pkg::ROOT_W-1:0]  out_root,
  input wire logic                        out_invalid
);

  // An invalid result never carries a root
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_root == '0))
    else $error("invalid result with non-zero root");

  // One request in flight: the block stalls right after taking one
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while previous one still in work");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_root) && $stable(out_invalid)))
    else $error("stalled result changed or dropped");

endmodule

bind newton_square_root nsr_checker u_nsr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_root    (out_root),
  .out_invalid (out_invalid)
);
`default_nettype wire

// ----- bench/tb_newton_square_root.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_newton_square_root
// Self-checking bench for the Newton square root block: requests go in
// through the valid/stall channel and each root is checked against a local
// fixed-point Newton predictor, across several tolerance and iteration limits.
// ----------------------------------------------------------------------------
module tb_newton_square_root;

  localparam int DW = nsr_pkg::DATA_WIDTH_DEF;
  localparam int FW = nsr_pkg::FRAC_BITS_DEF;

  // Longest legal wait: 255 Newton steps plus first guess,
  // a full receiver stall and a full sender gap, taken several times over.
  localparam int QUIET_LIMIT = 60000;
  localparam int HOLD_OFF    = 2000;

  typedef struct {
    logic [DW-1:0]              radicand;
    logic [nsr_pkg::ROOT_W-1:0] root;
    logic                       invalid;
  } root_check_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [DW-1:0]           in_value;
  logic                           out_valid;
  logic                           out_stall;
  logic [nsr_pkg::ROOT_W-1:0]     out_root;
  logic                           out_invalid;
  logic                           cfg_write_en;
  logic [nsr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [nsr_pkg::CFG_DATA_W-1:0] cfg_data;

  // Bench copy of the two registers, tracked on every write
  logic [nsr_pkg::TOL_W-1:0]  tol_cfg  = nsr_pkg::TOL_RESET;
  logic [nsr_pkg::ITER_W-1:0] iter_cfg = nsr_pkg::ITER_RESET;

  root_check_t expected_roots[$];

  int  mismatches     = 0;
  int  requests_sent  = 0;
  int  negatives_sent = 0;
  int  zeros_sent     = 0;
  int  roots_checked  = 0;
  int  settings_tried = 0;
  int  rx_hold_cycles = 0;
  bit  tx_idle_on     = 1'b1;
  bit  rx_idle_on     = 1'b1;

  newton_square_root DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_root     (out_root),
    .out_invalid  (out_invalid),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: fixed-point Newton-Heron root with the current register copy.
  // All arithmetic in 64 bits; (raw << 16) and diff << 32 both fit.
  // --------------------------------------------------------------------------
  function automatic root_check_t newton_root(input logic [DW-1:0] radicand);
    root_check_t res;
    logic [63:0] raw, mant, approx, x, prev, quot, diff;
    int lead, expo, half, k;
    res.radicand = radicand;
    res.root     = '0;
    res.invalid  = 1'b0;
    raw = 64'(radicand);
    // negative: flagged, no iterations
    if (radicand[DW-1]) begin
      res.invalid = 1'b1;
      return res;
    end
    if (raw == 64'd0) return res;

    // normalise: leading one to bit 15, dropped bits lost
    lead = DW - 1;
    while (lead > 0 && raw[lead] == 1'b0) lead--;
    if (lead >= 15) mant = raw >> (lead - 15);
    else            mant = raw << (15 - lead);
    approx = 64'(nsr_pkg::COEF_A) + ((64'(nsr_pkg::COEF_B) * mant) >> 16);
    expo = lead + 1 - FW;
    half = expo / 2;  // truncates towards zero
    if (half >= 0) x = approx << half;
    else           x = approx >> (-half);
    if (x == 64'd0) x = 64'd1 << FW;

    for (k = 0; k < int'(iter_cfg); k++) begin
      prev = x;
      if (x == 64'd0) x = 64'd1;
      quot = (raw << FW) / x;
      x    = (x + quot) >> 1;
      diff = (x >= prev) ? (x - prev) : (prev - x);
      if ((diff << 32) < (64'(tol_cfg) * x)) break;
    end

    if (x > 64'(nsr_pkg::ROOT_MAX)) x = 64'(nsr_pkg::ROOT_MAX);
    res.root = x[nsr_pkg::ROOT_W-1:0];
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch @%0t: %s", $realtime, msg);
  endfunction

  // Mostly positive radicands spread over all magnitudes, some tiny ones,
  // some zeros and a share of negatives.
  function automatic logic [DW-1:0] random_radicand();
    case ($urandom_range(0, 9))
      0:       return $urandom | 32'h8000_0000;
      1:       return $urandom_range(0, 3);
      2, 3:    return $urandom_range(1, 32'h0001_FFFF);
      default: return $urandom >> $urandom_range(1, 31);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one request per call. Valid stays high into the next call unless
  // a gap is drawn, so back-to-back requests never drop valid.
  // --------------------------------------------------------------------------
  task automatic send_radicand(input logic [DW-1:0] radicand);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= radicand;
    do @(posedge clk); while (in_stall);
    expected_roots.push_back(newton_root(radicand));
    requests_sent++;
    if (radicand[DW-1]) negatives_sent++;
    if (radicand == '0) zeros_sent++;
  endtask

  // Leaves write enable high; set_config lowers it after the last write.
  task automatic write_register(input logic [nsr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [nsr_pkg::CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    case (idx)
      nsr_pkg::CFG_TOLERANCE: tol_cfg  = data[nsr_pkg::TOL_W-1:0];
      nsr_pkg::CFG_MAX_ITER:  iter_cfg = data[nsr_pkg::ITER_W-1:0];
      default: ;
    endcase
  endtask

  // Registers only change with the block idle: every root back first.
  task automatic set_config(input logic [nsr_pkg::CFG_DATA_W-1:0] tol,
                            input logic [nsr_pkg::CFG_DATA_W-1:0] iter_word);
    in_valid <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    write_register(nsr_pkg::CFG_TOLERANCE, tol);
    write_register(nsr_pkg::CFG_MAX_ITER, iter_word);
    cfg_write_en <= 1'b0;
    settings_tried++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset register values; zero, smallest, largest, negative edges, exact
  // squares and scattered bit patterns.
  task automatic test_reset_defaults();
    logic [DW-1:0] corners[$];
    corners = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_8000,
                32'h0000_FFFF, 32'h0001_0000, 32'h0002_0000, 32'h0009_0000,
                32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                32'h5555_AAAA, 32'h1234_5678};
    foreach (corners[i]) send_radicand(corners[i]);
  endtask

  // Register extremes: zero tolerance with the full 255 steps, widest
  // tolerance with one step, no steps at all (first guess comes back), and
  // an iteration write with junk above bit 7.
  task automatic test_register_extremes();
    set_config(32'h0000_0000, 32'd255);
    send_radicand(32'h0000_0001);
    send_radicand(32'h7FFF_FFFF);
    set_config(32'hFFFF_FFFF, 32'd1);
    send_radicand(32'h0000_0003);
    send_radicand(32'h7FFF_FFFF);
    set_config(32'h0000_0001, 32'd0);
    send_radicand(32'h0000_0001);
    send_radicand(32'h7FFF_FFFF);
    send_radicand(32'h0000_8000);
    send_radicand(32'h8000_0001);
    send_radicand(32'h0000_0000);
    set_config(32'h8000_0000, 32'hFFFF_FF03);
    send_radicand(32'h0010_0000);
    send_radicand(32'h0000_0100);
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so
  // the output register fills and the block stalls its input.
  task automatic test_output_backpressure();
    int i;
    set_config(32'h0000_0000, 32'd2);
    tx_idle_on     = 1'b0;
    rx_hold_cycles = HOLD_OFF;
    for (i = 0; i < 10; i++) send_radicand(random_radicand());
    tx_idle_on = 1'b1;
  endtask

  // Random register settings, each followed by a batch of random radicands.
  // Iteration limits stay low so the run length stays sensible.
  task automatic test_random_settings(input int settings, input int per_setting);
    logic [nsr_pkg::TOL_W-1:0] tol;
    int s, i;
    for (s = 0; s < settings; s++) begin
      case ($urandom_range(0, 3))
        0:       tol = $urandom;
        1:       tol = 32'd1 << $urandom_range(16, 31);
        2:       tol = $urandom_range(0, 15);
        default: tol = $urandom_range(32'h0010_0000, 32'h0100_0000);
      endcase
      set_config(tol, $urandom_range(1, 12));
      for (i = 0; i < per_setting; i++) send_radicand(random_radicand());
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts and free stretches, or one long hold-off
  // when a test asks for it.
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    int span;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        span           = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on) begin
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // Checker: every accepted result against the oldest pending prediction.
  always @(posedge clk) begin : root_checker
    root_check_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_roots.size() == 0) begin
        note_failure($sformatf("unexpected result root=%h invalid=%b",
                               out_root, out_invalid));
      end else begin
        want = expected_roots.pop_front();
        roots_checked++;
        if (out_root !== want.root || out_invalid !== want.invalid)
          note_failure($sformatf("radicand %h: root %h invalid %b, want %h / %b",
                                 want.radicand, out_root, out_invalid,
                                 want.root, want.invalid));
      end
    end
  end

  // Watchdog: too long with no request or result moving ends the run.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
    $display("[newton_square_root] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_value     <= '0;
    cfg_write_en <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_output_backpressure();
    test_random_settings(10, 130);

    // closing stretch with both sides running flat out
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_settings(2, 75);

    in_valid <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    // settle time to catch any stray result
    repeat (64) @(posedge clk);
    if (expected_roots.size() != 0)
      note_failure($sformatf("%0d roots never arrived", expected_roots.size()));

    $display("Covered %0d radicands (%0d negative, %0d zero) over %0d register settings,",
             requests_sent, negatives_sent, zeros_sent, settings_tried);
    $display("with %0d roots compared and %0d mismatches.", roots_checked, mismatches);
    if (mismatches == 0) $display("[newton_square_root] OK");
    else $display("[newton_square_root] ERROR");
    $finish;
  end

endmodule
